// File: src/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants of the slab page allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int SIZE_W      = 12;   // object size field
  localparam int FRAG_W      = 32;   // full-precision free space / waste
  localparam int SHIFT_MAX   = 11;   // largest effective page shift
  localparam int SHIFT_RESET = 2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_BAD_RECORD = 2'd3
  } status_t;

endpackage

// File: src/spa_slab_mem.sv
// ----------------------------------------------------------------------------
// spa_slab_mem
// Per-slab state: page map, used page count and fragmentation. One write
// port, one registered read port; entries never written read as zero.
// ----------------------------------------------------------------------------
module spa_slab_mem
  import spa_pkg::*;
#(
  parameter int DEPTH = 12,
  parameter int PW    = 16,
  parameter int UW    = 5,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [AW-1:0]     raddr,
  output logic [PW-1:0]     rd_map,
  output logic [UW-1:0]     rd_used,
  output logic [FRAG_W-1:0] rd_frag,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [PW-1:0]     wr_map,
  input  logic [UW-1:0]     wr_used,
  input  logic [FRAG_W-1:0] wr_frag
);

  localparam int DW = PW + UW + FRAG_W;

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DW-1:0]    rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wr_map, wr_used, wr_frag};
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  // unwritten slabs read as reset value
  assign {rd_map, rd_used, rd_frag} = rd_vld ? rd_q : '0;

endmodule

// File: src/spa_rec_mem.sv
// ----------------------------------------------------------------------------
// spa_rec_mem
// Allocation record table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spa_rec_mem #(
  parameter int DEPTH = 16,
  parameter int DW    = 34,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/slab_page_allocator.sv
// ----------------------------------------------------------------------------
// slab_page_allocator
// Page-granular slab allocator: first-fit slab search, lowest-free-page
// selection, record table with compaction on free.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  cfg      | cfg_valid / cfg_ready  | cfg_data (page_shift)
//  in       | in_valid / in_ready    | mode, cache_id, object_size, record_index
//  out      | out_valid / out_ready  | status ... records_held
//
//  Allocate: a check, a read and a test per slab tested, a page scan, a
//  write; the scan walks one page per cycle and each slab test is one slab
//  memory read. Free: check, record and slab reads, update, then a read and
//  a write per record moved down. Errors end at the check, or after the slab
//  tests when no slab fits. One item is in work at a time; a new item is
//  taken while the last result waits in the output register, and the next
//  result holds in S_DONE until that register is free.
//  Reset clears slab state through per-slab valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module slab_page_allocator
  import spa_pkg::*;
#(
  parameter int NUM_CACHES      = 3,
  parameter int SLABS_PER_CACHE = 4,
  parameter int PAGES_PER_SLAB  = 16,
  parameter int RECORD_SLOTS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [1:0]  cache_id,
  input  logic [11:0] object_size,
  input  logic [3:0]  record_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [1:0]  slab_pos,
  output logic [3:0]  record_slot,
  output logic [15:0] page_mask,
  output logic [4:0]  page_count,
  output logic [15:0] slab_free_space,
  output logic [15:0] slab_waste,
  output logic [4:0]  records_held
);

  localparam int SLAB_TOTAL = NUM_CACHES * SLABS_PER_CACHE;
  localparam int SW     = (SLAB_TOTAL > 1) ? $clog2(SLAB_TOTAL) : 1;
  localparam int SIW    = (SLABS_PER_CACHE > 1) ? $clog2(SLABS_PER_CACHE) : 1;
  localparam int CAW    = (NUM_CACHES > 1) ? $clog2(NUM_CACHES) : 1;
  localparam int PW     = PAGES_PER_SLAB;
  localparam int PIW    = (PW > 1) ? $clog2(PW) : 1;
  localparam int UW     = $clog2(PW + 1);
  localparam int RIW    = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
  localparam int CW     = $clog2(RECORD_SLOTS + 1);
  localparam int NEED_W = SIZE_W + 1;
  localparam int REC_W  = SIW + CAW + SIZE_W + PW;

  typedef enum logic [3:0] {
    S_IDLE, S_A_CHK, S_A_RD, S_A_TEST, S_A_SCAN, S_A_WR,
    S_F_CHK, S_F_REC, S_F_RD, S_F_SLAB, S_F_UPD, S_F_MV_RD, S_F_MV_WR,
    S_DONE
  } state_t;

  state_t               state;
  logic [3:0]           page_shift;
  logic [3:0]           sh;
  logic [1:0]           op_cache;
  logic [SIZE_W-1:0]    op_size;
  logic [3:0]           op_idx;
  logic [SIW-1:0]       slab_i;
  logic [SW-1:0]        slab_addr;
  logic [PIW-1:0]       page_p;
  logic [UW-1:0]        taken;
  logic [NEED_W-1:0]    need;
  logic [PW-1:0]        sel_mask;
  logic [PW-1:0]        s_map;
  logic [UW-1:0]        s_used;
  logic [FRAG_W-1:0]    s_frag;
  logic [SIW-1:0]       rec_slab;
  logic [UW-1:0]        cnt;
  logic [FRAG_W-1:0]    waste;
  logic [CW-1:0]        mv_j;
  logic [CW-1:0]        record_total;
  logic [RIW-1:0]       rec_raddr;

  status_t              res_status;
  logic [SIW-1:0]       res_slab;
  logic [RIW-1:0]       res_slot;
  logic [PW-1:0]        res_mask;
  logic [UW-1:0]        res_cnt;
  logic [FRAG_W-1:0]    res_fs;
  logic [FRAG_W-1:0]    res_frag;

  // memory ports
  logic [PW-1:0]        sm_rd_map;
  logic [UW-1:0]        sm_rd_used;
  logic [FRAG_W-1:0]    sm_rd_frag;
  logic                 sm_we;
  logic [PW-1:0]        sm_wr_map;
  logic [UW-1:0]        sm_wr_used;
  logic [FRAG_W-1:0]    sm_wr_frag;
  logic [REC_W-1:0]     rm_rdata;
  logic                 rm_we;
  logic [RIW-1:0]       rm_waddr;
  logic [REC_W-1:0]     rm_wdata;

  // record fields
  logic [PW-1:0]        rd_mask;
  logic [SIZE_W-1:0]    rd_size;
  logic [CAW-1:0]       rd_cache;
  logic [SIW-1:0]       rd_slab;
  logic [UW-1:0]        rd_cnt;

  logic [FRAG_W-1:0]    test_fs;
  logic [UW-1:0]        a_used;
  logic [FRAG_W-1:0]    a_frag;
  logic [FRAG_W-1:0]    a_fs;
  logic [FRAG_W-1:0]    span;
  logic [UW-1:0]        f_used;
  logic [FRAG_W-1:0]    f_frag;
  logic [FRAG_W-1:0]    f_fs;

  assign sh        = (page_shift > 4'(SHIFT_MAX)) ? 4'(SHIFT_MAX) : page_shift;
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign {rd_slab, rd_cache, rd_size, rd_mask} = rm_rdata;

  always_comb begin
    rd_cnt = '0;
    for (int k = 0; k < PW; k++) begin
      rd_cnt = rd_cnt + UW'(rd_mask[k]);
    end
  end

  assign test_fs = (FRAG_W'(PW) - FRAG_W'(sm_rd_used)) << sh;
  assign a_used  = s_used + taken;
  assign a_frag  = s_frag + (FRAG_W'(taken) << sh) - FRAG_W'(op_size);
  assign a_fs    = (FRAG_W'(PW) - FRAG_W'(a_used)) << sh;
  assign span    = FRAG_W'(cnt) << sh;
  assign f_used  = (s_used > cnt) ? s_used - cnt : '0;
  assign f_frag  = (s_frag > waste) ? s_frag - waste : '0;
  assign f_fs    = (FRAG_W'(PW) - FRAG_W'(f_used)) << sh;

  always_comb begin
    sm_we      = 1'b0;
    sm_wr_map  = s_map | sel_mask;
    sm_wr_used = a_used;
    sm_wr_frag = a_frag;
    rm_we      = 1'b0;
    rm_waddr   = RIW'(record_total);
    rm_wdata   = {slab_i, CAW'(op_cache), op_size, sel_mask};
    case (state)
      S_A_WR: begin
        sm_we = 1'b1;
        rm_we = 1'b1;
      end
      S_F_UPD: begin
        sm_we      = 1'b1;
        sm_wr_map  = s_map & ~sel_mask;
        sm_wr_used = f_used;
        sm_wr_frag = f_frag;
      end
      S_F_MV_WR: begin
        rm_we    = 1'b1;
        rm_waddr = RIW'(mv_j - CW'(1));
        rm_wdata = rm_rdata;
      end
      default: ;
    endcase
  end

  spa_slab_mem #(
    .DEPTH (SLAB_TOTAL),
    .PW    (PW),
    .UW    (UW),
    .AW    (SW)
  ) u_slab_mem (
    .clk     (clk),
    .rst     (rst),
    .raddr   (slab_addr),
    .rd_map  (sm_rd_map),
    .rd_used (sm_rd_used),
    .rd_frag (sm_rd_frag),
    .we      (sm_we),
    .waddr   (slab_addr),
    .wr_map  (sm_wr_map),
    .wr_used (sm_wr_used),
    .wr_frag (sm_wr_frag)
  );

  spa_rec_mem #(
    .DEPTH (RECORD_SLOTS),
    .DW    (REC_W),
    .AW    (RIW)
  ) u_rec_mem (
    .clk   (clk),
    .raddr (rec_raddr),
    .rdata (rm_rdata),
    .we    (rm_we),
    .waddr (rm_waddr),
    .wdata (rm_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      page_shift   <= 4'(SHIFT_RESET);
      record_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        page_shift <= cfg_data;
      end
      // S_DONE reloads the output register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_cache  <= cache_id;
            op_size   <= object_size;
            op_idx    <= record_index;
            rec_raddr <= RIW'(record_index);
            state     <= (mode == MODE_FREE) ? S_F_CHK : S_A_CHK;
          end
        end
        S_A_CHK: begin
          slab_i    <= '0;
          slab_addr <= SW'(32'(op_cache) * SLABS_PER_CACHE);
          if (32'(record_total) >= RECORD_SLOTS) begin
            res_status <= ST_TABLE_FULL;
            state      <= S_DONE;
          end else if (32'(op_cache) >= NUM_CACHES) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            state <= S_A_RD;
          end
        end
        S_A_RD: begin
          state <= S_A_TEST;
        end
        S_A_TEST: begin
          if (test_fs > FRAG_W'(op_size)) begin
            s_map    <= sm_rd_map;
            s_used   <= sm_rd_used;
            s_frag   <= sm_rd_frag;
            need     <= NEED_W'(op_size >> sh) + NEED_W'(1);
            page_p   <= '0;
            taken    <= '0;
            sel_mask <= '0;
            state    <= S_A_SCAN;
          end else if (slab_i == SIW'(SLABS_PER_CACHE - 1)) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            slab_i    <= slab_i + SIW'(1);
            slab_addr <= slab_addr + SW'(1);
            state     <= S_A_RD;
          end
        end
        S_A_SCAN: begin
          // take the lowest free pages until enough are held
          if (!s_map[page_p] && (NEED_W'(taken) < need)) begin
            sel_mask[page_p] <= 1'b1;
            taken            <= taken + UW'(1);
          end
          if (page_p == PIW'(PW - 1)) begin
            state <= S_A_WR;
          end else begin
            page_p <= page_p + PIW'(1);
          end
        end
        S_A_WR: begin
          res_status   <= ST_OK;
          res_slab     <= slab_i;
          res_slot     <= RIW'(record_total);
          res_mask     <= sel_mask;
          res_cnt      <= taken;
          res_fs       <= a_fs;
          res_frag     <= a_frag;
          record_total <= record_total + CW'(1);
          state        <= S_DONE;
        end
        S_F_CHK: begin
          if (32'(op_idx) >= 32'(record_total)) begin
            res_status <= ST_BAD_RECORD;
            state      <= S_DONE;
          end else begin
            state <= S_F_REC;
          end
        end
        S_F_REC: begin
          rec_slab  <= rd_slab;
          op_size   <= rd_size;
          sel_mask  <= rd_mask;
          cnt       <= rd_cnt;
          slab_addr <= SW'(32'(rd_cache) * SLABS_PER_CACHE + 32'(rd_slab));
          state     <= S_F_RD;
        end
        S_F_RD: begin
          state <= S_F_SLAB;
        end
        S_F_SLAB: begin
          s_map  <= sm_rd_map;
          s_used <= sm_rd_used;
          s_frag <= sm_rd_frag;
          waste  <= (span > FRAG_W'(op_size)) ? span - FRAG_W'(op_size)
                                              : FRAG_W'(op_size) - span;
          state  <= S_F_UPD;
        end
        S_F_UPD: begin
          res_status <= ST_OK;
          res_slab   <= rec_slab;
          res_slot   <= RIW'(op_idx);
          res_mask   <= sel_mask;
          res_cnt    <= cnt;
          res_fs     <= f_fs;
          res_frag   <= f_frag;
          mv_j       <= CW'(op_idx) + CW'(1);
          rec_raddr  <= RIW'(CW'(op_idx) + CW'(1));
          if ((CW'(op_idx) + CW'(1)) < record_total) begin
            state <= S_F_MV_RD;
          end else begin
            record_total <= record_total - CW'(1);
            state        <= S_DONE;
          end
        end
        S_F_MV_RD: begin
          state <= S_F_MV_WR;
        end
        S_F_MV_WR: begin
          // shift one record down a slot
          mv_j      <= mv_j + CW'(1);
          rec_raddr <= RIW'(mv_j + CW'(1));
          if ((mv_j + CW'(1)) < record_total) begin
            state <= S_F_MV_RD;
          end else begin
            record_total <= record_total - CW'(1);
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            records_held <= 5'(record_total);
            if (res_status == ST_OK) begin
              slab_pos        <= 2'(res_slab);
              record_slot     <= 4'(res_slot);
              page_mask       <= 16'(res_mask);
              page_count      <= 5'(res_cnt);
              slab_free_space <= 16'(res_fs);
              slab_waste      <= 16'(res_frag);
            end else begin
              slab_pos        <= '0;
              record_slot     <= '0;
              page_mask       <= '0;
              page_count      <= '0;
              slab_free_space <= '0;
              slab_waste      <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(record_total) <= RECORD_SLOTS)
    else $error("record count beyond table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("accepted item did not start work");

  a_pages_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_WR) |-> (NEED_W'(taken) == need))
    else $error("page scan found too few pages");

  a_free_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_F_UPD) |-> (record_total != '0))
    else $error("free with empty record table");

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished result not loaded");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the slab page allocator: a directed table of
// allocate and free items, then random traffic that fills and drains the
// record table under several page sizes, checked against a behavioral model.
// ----------------------------------------------------------------------------
module tb
  import spa_pkg::*;
;

  localparam int NC = 3;
  localparam int SPC = 4;
  localparam int PPS = 16;
  localparam int NREC = 16;
  localparam int NSLAB = NC * SPC;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  slab_pos;
    logic [3:0]  record_slot;
    logic [15:0] page_mask;
    logic [4:0]  page_count;
    logic [15:0] slab_free_space;
    logic [15:0] slab_waste;
    logic [4:0]  records_held;
  } alloc_result_t;

  typedef struct packed {
    logic        mode;
    logic [1:0]  cache_id;
    logic [11:0] object_size;
    logic [3:0]  record_index;
  } request_t;

  typedef struct {
    request_t req;
    logic     has_fixed;
    alloc_result_t fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic [1:0] cache_id = '0;
  logic [11:0] object_size = '0;
  logic [3:0] record_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [1:0] slab_pos;
  logic [3:0] record_slot;
  logic [15:0] page_mask;
  logic [4:0] page_count;
  logic [15:0] slab_free_space;
  logic [15:0] slab_waste;
  logic [4:0] records_held;

  always #10 clk = ~clk;

  slab_page_allocator u_top (.*);

  // model state
  logic [3:0]  shift_reg;
  logic [15:0] used_map [NSLAB];
  int unsigned used_pages [NSLAB];
  int unsigned frag [NSLAB];
  int unsigned rec_slab [NREC];
  int unsigned rec_cache [NREC];
  int unsigned rec_size [NREC];
  logic [15:0] rec_mask [NREC];
  int unsigned live_records;

  alloc_result_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic int unsigned page_bits();
    return (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;
  endfunction

  function automatic int unsigned space_of(int s);
    return (PPS - used_pages[s]) << page_bits();
  endfunction

  function automatic alloc_result_t fail_result(status_t st);
    alloc_result_t r;
    r = '0;
    r.status = st;
    r.records_held = live_records[4:0];
    return r;
  endfunction

  function automatic alloc_result_t predict_alloc(request_t q);
    alloc_result_t r;
    int s;
    int found;
    int unsigned need, taken, sh;
    logic [15:0] m;
    found = 0;
    s = 0;
    taken = 0;
    m = '0;
    sh = page_bits();
    if (live_records >= NREC) return fail_result(ST_TABLE_FULL);
    if (q.cache_id < NC) begin
      for (int i = 0; i < SPC; i++) begin
        if (!found && space_of(q.cache_id * SPC + i) > q.object_size) begin
          found = 1;
          s = q.cache_id * SPC + i;
        end
      end
    end
    if (!found) return fail_result(ST_NO_SPACE);
    need = (q.object_size >> sh) + 1;
    for (int i = 0; i < PPS; i++) begin
      if (taken < need && !used_map[s][i]) begin
        m[i] = 1'b1;
        taken++;
      end
    end
    used_map[s] |= m;
    used_pages[s] += taken;
    frag[s] += (taken << sh) - q.object_size;
    rec_slab[live_records] = s - q.cache_id * SPC;
    rec_cache[live_records] = q.cache_id;
    rec_size[live_records] = q.object_size;
    rec_mask[live_records] = m;
    live_records++;
    r.status = ST_OK;
    r.slab_pos = 2'(rec_slab[live_records - 1]);
    r.record_slot = 4'(live_records - 1);
    r.page_mask = m;
    r.page_count = 5'(taken);
    r.slab_free_space = 16'(space_of(s));
    r.slab_waste = 16'(frag[s]);
    r.records_held = 5'(live_records);
    return r;
  endfunction

  function automatic alloc_result_t predict_free(request_t q);
    alloc_result_t r;
    int s;
    int unsigned cnt, span, waste;
    logic [15:0] m;
    if (q.record_index >= live_records) return fail_result(ST_BAD_RECORD);
    s = (rec_cache[q.record_index] * SPC + rec_slab[q.record_index]) % NSLAB;
    m = rec_mask[q.record_index];
    cnt = $countones(m);
    used_map[s] &= ~m;
    used_pages[s] = (used_pages[s] > cnt) ? used_pages[s] - cnt : 0;
    span = cnt << page_bits();
    waste = (span > rec_size[q.record_index]) ? span - rec_size[q.record_index]
                                               : rec_size[q.record_index] - span;
    frag[s] = (frag[s] > waste) ? frag[s] - waste : 0;
    r.status = ST_OK;
    r.slab_pos = 2'(rec_slab[q.record_index]);
    r.record_slot = q.record_index;
    r.page_mask = m;
    r.page_count = 5'(cnt);
    for (int i = q.record_index + 1; i < live_records; i++) begin
      rec_slab[i - 1] = rec_slab[i];
      rec_cache[i - 1] = rec_cache[i];
      rec_size[i - 1] = rec_size[i];
      rec_mask[i - 1] = rec_mask[i];
    end
    live_records--;
    r.slab_free_space = 16'(space_of(s));
    r.slab_waste = 16'(frag[s]);
    r.records_held = 5'(live_records);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // drop valid only when the gap is not empty
  task automatic short_gap(int max_long);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, max_long) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // returns at the falling edge after the item is taken, valid still high
  task automatic send_item(request_t q, logic has_fixed, alloc_result_t fixed);
    alloc_result_t r;
    mode <= q.mode;
    cache_id <= q.cache_id;
    object_size <= q.object_size;
    record_index <= q.record_index;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = (q.mode == MODE_ALLOC) ? predict_alloc(q) : predict_free(q);
    expected_q.push_back(has_fixed ? fixed : r);
    @(negedge clk);
  endtask

  task automatic write_shift(logic [3:0] v);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shift_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic request_t mk(logic md, int c, int sz, int ri);
    request_t q;
    q.mode = md;
    q.cache_id = 2'(c);
    q.object_size = 12'(sz);
    q.record_index = 4'(ri);
    return q;
  endfunction

  function automatic alloc_result_t ok_res(int sl, int slot, int m, int cnt, int fs,
                                           int w, int held);
    alloc_result_t r;
    r.status = ST_OK;
    r.slab_pos = 2'(sl);
    r.record_slot = 4'(slot);
    r.page_mask = 16'(m);
    r.page_count = 5'(cnt);
    r.slab_free_space = 16'(fs);
    r.slab_waste = 16'(w);
    r.records_held = 5'(held);
    return r;
  endfunction

  // output checker and random back-pressure
  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {status, slab_pos, record_slot, page_mask, page_count,
             slab_free_space, slab_waste, records_held};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.status != want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.slab_pos != want.slab_pos)
          report_mismatch("slab_pos", int'(got.slab_pos), int'(want.slab_pos));
        if (got.record_slot != want.record_slot)
          report_mismatch("record_slot", int'(got.record_slot), int'(want.record_slot));
        if (got.page_mask != want.page_mask)
          report_mismatch("page_mask", int'(got.page_mask), int'(want.page_mask));
        if (got.page_count != want.page_count)
          report_mismatch("page_count", int'(got.page_count), int'(want.page_count));
        if (got.slab_free_space != want.slab_free_space)
          report_mismatch("slab_free_space", int'(got.slab_free_space),
                          int'(want.slab_free_space));
        if (got.slab_waste != want.slab_waste)
          report_mismatch("slab_waste", int'(got.slab_waste), int'(want.slab_waste));
        if (got.records_held != want.records_held)
          report_mismatch("records_held", int'(got.records_held),
                          int'(want.records_held));
      end
    end
  end

  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rst) out_ready <= 1'b0;
    else if (r < 70) out_ready <= 1'b1;
    else if (r < 97) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 1) == 0);
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    request_t q;
    int c, sz;
    logic [3:0] shifts [6];
    shift_reg = SHIFT_RESET;
    for (int i = 0; i < NSLAB; i++) begin
      used_map[i] = '0;
      used_pages[i] = 0;
      frag[i] = 0;
    end
    live_records = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, page size 4 after reset
    row.has_fixed = 1'b1;
    row.req = mk(MODE_FREE, 0, 0, 0);
    row.fixed = '0; row.fixed.status = ST_BAD_RECORD; rows.push_back(row);
    row.req = mk(MODE_ALLOC, 3, 5, 0);
    row.fixed = '0; row.fixed.status = ST_NO_SPACE; rows.push_back(row);
    row.req = mk(MODE_ALLOC, 0, 0, 0);
    row.fixed = ok_res(0, 0, 16'h0001, 1, 60, 4, 1); rows.push_back(row);
    row.req = mk(MODE_ALLOC, 0, 4095, 0);
    row.fixed = '0; row.fixed.status = ST_NO_SPACE; row.fixed.records_held = 1;
    rows.push_back(row);
    row.req = mk(MODE_ALLOC, 0, 59, 0);
    row.fixed = ok_res(0, 1, 16'hFFFE, 15, 0, 5, 2); rows.push_back(row);
    row.has_fixed = 1'b0;
    row.req = mk(MODE_ALLOC, 0, 63, 0); rows.push_back(row);
    row.req = mk(MODE_ALLOC, 1, 7, 0); rows.push_back(row);
    row.req = mk(MODE_ALLOC, 2, 2730, 0); rows.push_back(row);
    row.req = mk(MODE_FREE, 0, 0, 15); rows.push_back(row);
    row.req = mk(MODE_FREE, 0, 0, 0); rows.push_back(row);
    for (int i = 0; i < 14; i++) begin
      row.req = mk(MODE_ALLOC, i % 3, i, 0); rows.push_back(row);
    end
    row.req = mk(MODE_FREE, 0, 0, 1); rows.push_back(row);
    foreach (rows[i]) begin
      send_item(rows[i].req, rows[i].has_fixed, rows[i].fixed);
      short_gap(20);
    end
    // fill to full then table-full case
    while (live_records < NREC)
      send_item(mk(MODE_ALLOC, $urandom_range(0, 2), $urandom_range(0, 3), 0), 0, '0);
    send_item(mk(MODE_ALLOC, 0, 0, 0), 0, '0);

    // random phases across page sizes; page size changes while records live
    shifts = '{4'd0, 4'd11, 4'd15, 4'd5, 4'd2, 4'd8};
    for (int p = 0; p < 6; p++) begin
      write_shift(shifts[p]);
      for (int k = 0; k < 270; k++) begin
        q = '0;
        q.cache_id = 2'($urandom);
        q.object_size = 12'($urandom);
        q.record_index = 4'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          q.mode = 1'($urandom);
        end else begin
          q.mode = (live_records >= NREC - 1) ? ($urandom_range(0, 3) != 0)
                 : (live_records < 3) ? ($urandom_range(0, 4) == 0)
                 : 1'($urandom);
          if (q.mode == MODE_ALLOC) begin
            c = $urandom_range(0, 2);
            q.cache_id = 2'(c);
            sz = ((PPS << page_bits()) > 1) ? $urandom_range(0, (PPS << page_bits()) / 3) : 0;
            if ($urandom_range(0, 7) == 0) sz = $urandom;
            q.object_size = 12'(sz);
          end else if (live_records > 0) begin
            q.record_index = 4'($urandom_range(0, live_records - 1));
          end
        end
        send_item(q, 0, '0);
        if (k == 135 && p == 2) begin
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(negedge clk);
        end
        short_gap(30);
      end
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
